>>> rtl/core/rff_pkg.sv
package rff_pkg;

  localparam int GRID_SIZE = 128;
  localparam int DEPTH = GRID_SIZE * GRID_SIZE;
  localparam int ADDR_W = $clog2(DEPTH);
  // wide enough for origin plus extent and for the grid edge itself
  localparam int END_W = ($clog2(GRID_SIZE + 1) > 9) ? $clog2(GRID_SIZE + 1) : 9;
  localparam int PIXEL_W = 24;
  localparam logic [PIXEL_W-1:0] WHITE_PIXEL = 24'hFF_FFFF;
  localparam logic [END_W-1:0] GRID_END = END_W'(GRID_SIZE);

  localparam logic REQ_DRAW = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [6:0] origin_x;
    logic [6:0] origin_y;
    logic [7:0] rect_width;
    logic [7:0] rect_height;
    logic [7:0] fill_red;
    logic [7:0] fill_green;
    logic [7:0] fill_blue;
    logic [6:0] read_x;
    logic [6:0] read_y;
  } rff_req_t;

  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic [7:0] tallest_seen;
    logic [7:0] widest_seen;
    logic       clipped;
  } rff_rsp_t;

  // rectangle handed to the walker
  typedef struct packed {
    logic [END_W-1:0] x0;
    logic [END_W-1:0] y0;
    logic [END_W-1:0] x_end;
    logic [END_W-1:0] y_end;
  } rff_span_t;

  function automatic logic [ADDR_W-1:0] grid_addr(input logic [END_W-1:0] y,
                                                  input logic [END_W-1:0] x);
    logic [ADDR_W+END_W-1:0] p;
    p = (ADDR_W + END_W)'(y) * (ADDR_W + END_W)'(GRID_SIZE) + (ADDR_W + END_W)'(x);
    return p[ADDR_W-1:0];
  endfunction

endpackage

>>> rtl/core/rff_if.sv
interface rff_req_if import rff_pkg::*; ();
  logic     valid;
  logic     ready;
  rff_req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rff_rsp_if import rff_pkg::*; ();
  logic     valid;
  logic     ready;
  rff_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/rff_ram.sv
module rff_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> rtl/core/rff_walker.sv
module rff_walker import rff_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  rff_span_t        span,
  input  logic             step,
  output logic [END_W-1:0] x,
  output logic [END_W-1:0] y,
  output logic             last
);

  logic [END_W-1:0] x0;
  logic [END_W-1:0] x_end;
  logic [END_W-1:0] y_end;
  logic             row_end;

  assign row_end = (x + END_W'(1)) == x_end;
  assign last    = row_end && ((y + END_W'(1)) == y_end);

  // reset loads the whole grid so the store gets swept to white
  always_ff @(posedge clk) begin
    if (rst) begin
      x     <= '0;
      y     <= '0;
      x0    <= '0;
      x_end <= GRID_END;
      y_end <= GRID_END;
    end else if (start) begin
      x     <= span.x0;
      y     <= span.y0;
      x0    <= span.x0;
      x_end <= span.x_end;
      y_end <= span.y_end;
    end else if (step) begin
      if (row_end) begin
        x <= x0;
        y <= y + END_W'(1);
      end else begin
        x <= x + END_W'(1);
      end
    end
  end

endmodule

>>> rtl/core/rff_ctrl.sv
module rff_ctrl import rff_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  rff_req_if.sink  request,
  output logic     res_valid,
  output rff_rsp_t res,
  input  logic     res_ready
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAW,
    ST_READ_ADDR,
    ST_READ_DATA,
    ST_RESULT
  } state_t;

  state_t              state;
  logic [PIXEL_W-1:0]  colour;
  logic [PIXEL_W-1:0]  res_pixel;
  logic                res_clip;
  logic [7:0]          max_height;
  logic [7:0]          max_width;
  logic [ADDR_W-1:0]   rd_addr;
  logic                rd_inside;

  logic                accept;
  logic [END_W-1:0]    ox;
  logic [END_W-1:0]    oy;
  logic [END_W-1:0]    x_sum;
  logic [END_W-1:0]    y_sum;
  logic [END_W-1:0]    x_lim;
  logic [END_W-1:0]    y_lim;
  logic                empty;
  logic                clip;
  rff_span_t           span;
  logic                walk_start;
  logic                walk_step;
  logic [END_W-1:0]    walk_x;
  logic [END_W-1:0]    walk_y;
  logic                walk_last;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_addr;
  logic [PIXEL_W-1:0]  ram_rdata;

  assign request.ready = (state == ST_IDLE);
  assign accept = request.valid && request.ready;

  always_comb begin
    ox    = END_W'(request.data.origin_x);
    oy    = END_W'(request.data.origin_y);
    x_sum = ox + END_W'(request.data.rect_width);
    y_sum = oy + END_W'(request.data.rect_height);
    x_lim = (x_sum > GRID_END) ? GRID_END : x_sum;
    y_lim = (y_sum > GRID_END) ? GRID_END : y_sum;
    // zero extent or origin past the edge paints nothing
    empty = (ox >= x_lim) || (oy >= y_lim);
    clip  = (request.data.rect_width != 8'd0) && (request.data.rect_height != 8'd0) &&
            ((x_sum > GRID_END) || (y_sum > GRID_END));
    span.x0    = ox;
    span.y0    = oy;
    span.x_end = x_lim;
    span.y_end = y_lim;
  end

  assign walk_start = accept && (request.data.req_type == REQ_DRAW) && !empty;
  assign ram_we     = (state == ST_CLEAR) || (state == ST_DRAW);
  assign walk_step  = ram_we;
  assign ram_addr   = (state == ST_READ_ADDR) ? rd_addr : grid_addr(walk_y, walk_x);

  rff_walker u_walker (
    .clk   (clk),
    .rst   (rst),
    .start (walk_start),
    .span  (span),
    .step  (walk_step),
    .x     (walk_x),
    .y     (walk_y),
    .last  (walk_last)
  );

  rff_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (colour),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      colour     <= WHITE_PIXEL;
      max_height <= '0;
      max_width  <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          if (walk_last) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (request.data.req_type == REQ_DRAW) begin
              if (request.data.rect_height > max_height) begin
                max_height <= request.data.rect_height;
              end
              if (request.data.rect_width > max_width) begin
                max_width <= request.data.rect_width;
              end
              colour    <= {request.data.fill_red, request.data.fill_green,
                            request.data.fill_blue};
              res_pixel <= '0;
              res_clip  <= clip;
              state     <= empty ? ST_RESULT : ST_DRAW;
            end else begin
              rd_addr   <= grid_addr(END_W'(request.data.read_y),
                                     END_W'(request.data.read_x));
              rd_inside <= (END_W'(request.data.read_x) < GRID_END) &&
                           (END_W'(request.data.read_y) < GRID_END);
              res_clip  <= 1'b0;
              state     <= ST_READ_ADDR;
            end
          end
        end
        ST_DRAW: begin
          if (walk_last) begin
            state <= ST_RESULT;
          end
        end
        ST_READ_ADDR: begin
          state <= ST_READ_DATA;
        end
        ST_READ_DATA: begin
          res_pixel <= rd_inside ? ram_rdata : WHITE_PIXEL;
          state     <= ST_RESULT;
        end
        ST_RESULT: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign res_valid = (state == ST_RESULT);

  always_comb begin
    res.pixel_red    = res_pixel[23:16];
    res.pixel_green  = res_pixel[15:8];
    res.pixel_blue   = res_pixel[7:0];
    res.tallest_seen = max_height;
    res.widest_seen  = max_width;
    res.clipped      = res_clip;
  end

endmodule

>>> rtl/core/rectangle_fill_frame_store.sv
// draw: the request is taken, then one pixel is painted per cycle (clipped width times
// clipped height, one store write each), then the result goes to the output register
// read: ST_READ_ADDR drives the store's registered read port, ST_READ_DATA takes the pixel
// one request at a time; the next request is taken while a result waits in the output register
// reset: synchronous; the store is then swept to white, GRID_SIZE*GRID_SIZE (16384) pixels,
// during which no request is taken; both maxima clear to zero
module rectangle_fill_frame_store import rff_pkg::*; (
  input logic      clk,
  input logic      rst,
  rff_req_if.sink  request,
  rff_rsp_if.source result
);

  logic     res_valid;
  logic     res_ready;
  rff_rsp_t res;
  logic     out_valid;
  rff_rsp_t out_data;

  rff_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .request   (request),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  assign res_ready = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data <= res;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

endmodule
